// ----- src/assert_macros.svh -----
// assertion helpers shared by the wav to pwm block
// every user must have clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define WSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent on one edge, consequent on the next edge
`define WSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/wsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants of the wav stream to pwm converter.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // input word function codes
  localparam logic [1:0] FUNC_NEXT = 2'd0;
  localparam logic [1:0] FUNC_NEW  = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;

  // pwm level for silence
  localparam logic [7:0] PWM_MIDPOINT = 8'd128;

  // header tags, first byte in the top lane
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // byte positions inside the fixed header
  localparam logic [5:0] POS_RIFF_LAST = 6'd3;
  localparam logic [5:0] POS_WAVE_LAST = 6'd11;
  localparam logic [5:0] POS_FMT       = 6'd20;
  localparam logic [5:0] POS_CHAN      = 6'd22;
  localparam logic [5:0] POS_RATE      = 6'd24;
  localparam logic [5:0] POS_BRATE     = 6'd28;
  localparam logic [5:0] POS_ALIGN     = 6'd32;
  localparam logic [5:0] POS_BITS      = 6'd34;
  localparam logic [5:0] POS_HDR_LAST  = 6'd35;
  localparam logic [5:0] POS_SIZE_LAST = 6'd3;

  // header values that mark wide samples and stereo
  localparam logic [15:0] BITS_WIDE    = 16'd16;
  localparam logic [15:0] CHAN_STEREO  = 16'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SEARCH,
    PH_SIZE,
    PH_PLAY,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FORMAT,
    KIND_SAMPLE,
    KIND_ERROR,
    KIND_END
  } kind_t;

  // format values read from the header
  typedef struct packed {
    logic [15:0] format_code;
    logic [15:0] channels;
    logic [15:0] bits;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [31:0] data_size;
  } hdr_t;

  // result produced by one processed word
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] pwm;
  } emit_t;

endpackage

// ----- src/wsp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_in_if
// Byte stream channel into the converter.
// ----------------------------------------------------------------------------
interface wsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] file_byte;

  modport source (output valid, output func, output file_byte, input ready);
  modport sink   (input valid, input func, input file_byte, output ready);
endinterface

// ----- src/wsp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_out_if
// Result channel out of the converter.
// ----------------------------------------------------------------------------
interface wsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  pulse_width;
  logic [15:0] format_code;
  logic [15:0] channel_count;
  logic [15:0] sample_bits;
  logic [31:0] sample_rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [31:0] data_size;

  modport source (
    output valid, output kind, output pulse_width, output format_code,
    output channel_count, output sample_bits, output sample_rate,
    output byte_rate, output block_align, output data_size, input ready
  );
  modport sink (
    input valid, input kind, input pulse_width, input format_code,
    input channel_count, input sample_bits, input sample_rate,
    input byte_rate, input block_align, input data_size, output ready
  );
endinterface

// ----- src/wsp_level.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_level
// Sample to pwm level conversion and stereo mixing.
// ----------------------------------------------------------------------------
module wsp_level (
  input  logic       wide,
  input  logic [7:0] low_byte,
  input  logic [7:0] file_byte,
  input  logic [7:0] first_level,
  output logic [7:0] level,
  output logic [7:0] mix
);

  logic [15:0] sample;
  logic [15:0] neg;
  logic [8:0]  sum;

  // 8-bit samples pass through; a signed 16-bit sample is divided by 256 toward zero, offset to midpoint
  always_comb begin
    sample = {file_byte, low_byte};
    neg    = 16'(~sample + 16'd1);
    if (!wide) begin
      level = file_byte;
    end else if (sample[15]) begin
      level = 8'(wsp_pkg::PWM_MIDPOINT - neg[15:8]);
    end else begin
      level = 8'(wsp_pkg::PWM_MIDPOINT + sample[15:8]);
    end
  end

  // floored mean of both channels
  assign sum = {1'b0, first_level} + {1'b0, level};
  assign mix = sum[8:1];

endmodule

// ----- src/wsp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_ctrl
// Header parser, data tag search and frame assembly for one word per cycle while step is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [1:0]        func,
  input  logic [7:0]        file_byte,
  output wsp_pkg::emit_t    emit,
  output wsp_pkg::hdr_t     hdr
);

  wsp_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]      hpos_r, hpos_nxt;
  logic [31:0]     win_r, win_nxt;
  wsp_pkg::hdr_t   hdr_r, hdr_nxt;
  logic [7:0]      low_r, low_nxt;
  logic [7:0]      first_r, first_nxt;
  logic [1:0]      frame_r, frame_nxt;

  logic [31:0] win_shift;
  logic        wide;
  logic        stereo;
  logic [1:0]  frame_last;
  logic [7:0]  level;
  logic [7:0]  mix;

  assign win_shift = {win_r[23:0], file_byte};
  assign wide      = (hdr_r.bits == wsp_pkg::BITS_WIDE);
  assign stereo    = (hdr_r.channels == wsp_pkg::CHAN_STEREO);
  assign hdr       = hdr_r;

  // last byte position of a frame
  always_comb begin
    unique case ({stereo, wide})
      2'b00:   frame_last = 2'd0;
      2'b01:   frame_last = 2'd1;
      2'b10:   frame_last = 2'd1;
      default: frame_last = 2'd3;
    endcase
  end

  wsp_level u_level (
    .wide        (wide),
    .low_byte    (low_r),
    .file_byte   (file_byte),
    .first_level (first_r),
    .level       (level),
    .mix         (mix)
  );

  // next state and result for the word being processed
  always_comb begin
    phase_nxt  = phase_r;
    hpos_nxt   = hpos_r;
    win_nxt    = win_r;
    hdr_nxt    = hdr_r;
    low_nxt    = low_r;
    first_nxt  = first_r;
    frame_nxt  = frame_r;
    emit.valid = 1'b0;
    emit.kind  = wsp_pkg::KIND_FORMAT;
    emit.pwm   = 8'd0;
    if (step) begin
      unique case (func)
        wsp_pkg::FUNC_NEW: begin
          // byte 0 of a new file, everything else cleared
          phase_nxt = wsp_pkg::PH_HEADER;
          hpos_nxt  = 6'd1;
          win_nxt   = {24'd0, file_byte};
          hdr_nxt   = '0;
          low_nxt   = 8'd0;
          first_nxt = 8'd0;
          frame_nxt = 2'd0;
        end
        wsp_pkg::FUNC_END: begin
          unique case (phase_r)
            wsp_pkg::PH_HEADER, wsp_pkg::PH_SEARCH, wsp_pkg::PH_SIZE: begin
              phase_nxt  = wsp_pkg::PH_STOP;
              emit.valid = 1'b1;
              emit.kind  = wsp_pkg::KIND_ERROR;
            end
            wsp_pkg::PH_PLAY: begin
              phase_nxt  = wsp_pkg::PH_STOP;
              frame_nxt  = 2'd0;
              emit.valid = 1'b1;
              emit.kind  = wsp_pkg::KIND_END;
              emit.pwm   = wsp_pkg::PWM_MIDPOINT;
            end
            default: begin
            end
          endcase
        end
        wsp_pkg::FUNC_NEXT: begin
          unique case (phase_r)
            wsp_pkg::PH_HEADER: begin
              win_nxt = win_shift;
              if ((hpos_r == wsp_pkg::POS_RIFF_LAST && win_shift != wsp_pkg::TAG_RIFF) ||
                  (hpos_r == wsp_pkg::POS_WAVE_LAST && win_shift != wsp_pkg::TAG_WAVE)) begin
                phase_nxt  = wsp_pkg::PH_STOP;
                emit.valid = 1'b1;
                emit.kind  = wsp_pkg::KIND_ERROR;
              end else begin
                // little-endian fmt fields
                if (hpos_r >= wsp_pkg::POS_BITS) begin
                  hdr_nxt.bits[{hpos_r[0], 3'b000} +: 8] = file_byte;
                end else if (hpos_r >= wsp_pkg::POS_ALIGN) begin
                  hdr_nxt.block_align[{hpos_r[0], 3'b000} +: 8] = file_byte;
                end else if (hpos_r >= wsp_pkg::POS_BRATE) begin
                  hdr_nxt.byte_rate[{hpos_r[1:0], 3'b000} +: 8] = file_byte;
                end else if (hpos_r >= wsp_pkg::POS_RATE) begin
                  hdr_nxt.sample_rate[{hpos_r[1:0], 3'b000} +: 8] = file_byte;
                end else if (hpos_r >= wsp_pkg::POS_CHAN) begin
                  hdr_nxt.channels[{hpos_r[0], 3'b000} +: 8] = file_byte;
                end else if (hpos_r >= wsp_pkg::POS_FMT) begin
                  hdr_nxt.format_code[{hpos_r[0], 3'b000} +: 8] = file_byte;
                end
                if (hpos_r == wsp_pkg::POS_HDR_LAST) begin
                  phase_nxt = wsp_pkg::PH_SEARCH;
                  win_nxt   = 32'd0;
                  hpos_nxt  = 6'd0;
                end else begin
                  hpos_nxt = hpos_r + 6'd1;
                end
              end
            end
            wsp_pkg::PH_SEARCH: begin
              win_nxt = win_shift;
              if (win_shift == wsp_pkg::TAG_DATA) begin
                phase_nxt         = wsp_pkg::PH_SIZE;
                hpos_nxt          = 6'd0;
                hdr_nxt.data_size = 32'd0;
              end
            end
            wsp_pkg::PH_SIZE: begin
              hdr_nxt.data_size[{hpos_r[1:0], 3'b000} +: 8] = file_byte;
              if (hpos_r == wsp_pkg::POS_SIZE_LAST) begin
                hpos_nxt   = 6'd0;
                phase_nxt  = wsp_pkg::PH_PLAY;
                frame_nxt  = 2'd0;
                emit.valid = 1'b1;
                emit.kind  = wsp_pkg::KIND_FORMAT;
              end else begin
                hpos_nxt = hpos_r + 6'd1;
              end
            end
            wsp_pkg::PH_PLAY: begin
              if (wide && !frame_r[0]) begin
                low_nxt   = file_byte;
                frame_nxt = frame_r + 2'd1;
              end else if (frame_r < frame_last) begin
                first_nxt = level;
                frame_nxt = frame_r + 2'd1;
              end else begin
                frame_nxt  = 2'd0;
                emit.valid = 1'b1;
                emit.kind  = wsp_pkg::KIND_SAMPLE;
                emit.pwm   = stereo ? mix : level;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsp_pkg::PH_IDLE;
      hpos_r  <= 6'd0;
      win_r   <= 32'd0;
      hdr_r   <= '0;
      low_r   <= 8'd0;
      first_r <= 8'd0;
      frame_r <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      hpos_r  <= hpos_nxt;
      win_r   <= win_nxt;
      hdr_r   <= hdr_nxt;
      low_r   <= low_nxt;
      first_r <= first_nxt;
      frame_r <= frame_nxt;
    end
  end

  `WSP_ASSERT(a_play_hpos_clear, (phase_r == wsp_pkg::PH_PLAY) |-> (hpos_r == 6'd0), "header position not cleared while playing")
  `WSP_ASSERT(a_narrow_mono_frame, (phase_r == wsp_pkg::PH_PLAY && !wide && !stereo) |-> (frame_r == 2'd0), "frame position moved for 8-bit mono")
  `WSP_ASSERT_NEXT(a_new_file_header, step && func == wsp_pkg::FUNC_NEW, phase_r == wsp_pkg::PH_HEADER && hpos_r == 6'd1, "new file did not start header parse")

endmodule

// ----- src/wav_stream_to_pwm_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_stream_to_pwm_converter
// Parses a WAV byte stream and turns its samples into 8-bit pwm levels.
// ----------------------------------------------------------------------------
// channel  | direction | payload
// in_if    | sink      | func, file_byte
// out_if   | source    | kind, pulse_width, format fields from the header
//
// one word accepted per cycle while results are taken; its result becomes valid once
// it has passed the input register and then the result register beside the parser state
// rst_n is synchronous; no clearing pass, the block is ready right after reset
// a stalled result holds the parser; one more word waits in the input register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wav_stream_to_pwm_converter (
  input  logic      clk,
  input  logic      rst_n,
  wsp_in_if.sink    in_if,
  wsp_out_if.source out_if
);

  logic           in_v_r, in_v_nxt;
  logic [1:0]     in_func_r;
  logic [7:0]     in_byte_r;
  logic           out_v_r, out_v_nxt;
  wsp_pkg::kind_t out_kind_r;
  logic [7:0]     out_pwm_r;
  logic           step;
  wsp_pkg::emit_t emit;
  wsp_pkg::hdr_t  hdr;

  // word in the input register moves on when the result slot is free
  assign step         = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready  = !in_v_r || step;
  assign in_v_nxt     = in_if.valid || (in_v_r && !step);
  assign out_v_nxt    = step ? emit.valid : (out_v_r && !out_if.ready);

  wsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .func      (in_func_r),
    .file_byte (in_byte_r),
    .emit      (emit),
    .hdr       (hdr)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // input and result payload
  always_ff @(posedge clk) begin
    if (in_if.ready) begin
      in_func_r <= in_if.func;
      in_byte_r <= in_if.file_byte;
    end
    if (step) begin
      out_kind_r <= emit.kind;
      out_pwm_r  <= emit.pwm;
    end
  end

  // header values are stable while a result waits
  assign out_if.valid         = out_v_r;
  assign out_if.kind          = out_kind_r;
  assign out_if.pulse_width   = out_pwm_r;
  assign out_if.format_code   = hdr.format_code;
  assign out_if.channel_count = hdr.channels;
  assign out_if.sample_bits   = hdr.bits;
  assign out_if.sample_rate   = hdr.sample_rate;
  assign out_if.byte_rate     = hdr.byte_rate;
  assign out_if.block_align   = hdr.block_align;
  assign out_if.data_size     = hdr.data_size;

  `WSP_ASSERT_NEXT(a_word_held, in_v_r && !step, in_v_r && $stable(in_func_r) && $stable(in_byte_r), "waiting word lost")
  `WSP_ASSERT_NEXT(a_result_kept, out_v_r && !out_if.ready, out_v_r && $stable(hdr), "header changed under a waiting result")

endmodule

// ----- tb/wav_stream_to_pwm_converter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_stream_to_pwm_converter_test
// Feeds whole and broken WAV files into the converter one byte word at a time
// and checks each result word against a software copy of the parser.
// ----------------------------------------------------------------------------
module wav_stream_to_pwm_converter_test;

  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [31:0] TAG_FMT     = 32'h666d_7420;
  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [15:0] CHAN_MONO   = 16'd1;
  localparam logic [15:0] BITS_NARROW = 16'd8;
  localparam int          HOLD_CYCLES = 300;
  localparam int          TAIL_CYCLES = 12;

  // one expected result word
  typedef struct packed {
    wsp_pkg::kind_t kind;
    logic [7:0]     pwm;
    wsp_pkg::hdr_t  hdr;
  } pwm_result_t;

  logic clk;
  logic rst_n;

  wsp_in_if  in_ch();
  wsp_out_if out_ch();

  wav_stream_to_pwm_converter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // parser copy state
  wsp_pkg::phase_t ph;
  logic [5:0]      hpos;
  logic [31:0]     window;
  wsp_pkg::hdr_t   hv;
  logic [7:0]      low_byte;
  logic [7:0]      first_level;
  logic [1:0]      fpos;

  pwm_result_t awaited_results[$];
  logic [7:0]  file_bytes[$];

  int errors = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int hold_cycles = 0;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- parser copy

  task automatic model_clear();
    ph          = wsp_pkg::PH_IDLE;
    hpos        = '0;
    window      = '0;
    hv          = '0;
    low_byte    = '0;
    first_level = '0;
    fpos        = '0;
  endtask

  task automatic note_result(input wsp_pkg::kind_t k, input logic [7:0] pwm);
    pwm_result_t r;
    r.kind = k;
    r.pwm  = pwm;
    r.hdr  = hv;
    awaited_results.push_back(r);
  endtask

  // fixed header: tags at 0-3 and 8-11, fmt fields little-endian at 20-35
  task automatic model_header_byte(input logic [7:0] b);
    window = {window[23:0], b};
    if ((hpos == wsp_pkg::POS_RIFF_LAST && window != wsp_pkg::TAG_RIFF) ||
        (hpos == wsp_pkg::POS_WAVE_LAST && window != wsp_pkg::TAG_WAVE)) begin
      ph = wsp_pkg::PH_STOP;
      note_result(wsp_pkg::KIND_ERROR, 8'd0);
    end else begin
      if (hpos >= wsp_pkg::POS_FMT && hpos < wsp_pkg::POS_CHAN)
        hv.format_code = hv.format_code |
                         (16'(b) << (8 * int'(hpos - wsp_pkg::POS_FMT)));
      else if (hpos >= wsp_pkg::POS_CHAN && hpos < wsp_pkg::POS_RATE)
        hv.channels = hv.channels |
                      (16'(b) << (8 * int'(hpos - wsp_pkg::POS_CHAN)));
      else if (hpos >= wsp_pkg::POS_RATE && hpos < wsp_pkg::POS_BRATE)
        hv.sample_rate = hv.sample_rate |
                         (32'(b) << (8 * int'(hpos - wsp_pkg::POS_RATE)));
      else if (hpos >= wsp_pkg::POS_BRATE && hpos < wsp_pkg::POS_ALIGN)
        hv.byte_rate = hv.byte_rate |
                       (32'(b) << (8 * int'(hpos - wsp_pkg::POS_BRATE)));
      else if (hpos >= wsp_pkg::POS_ALIGN && hpos < wsp_pkg::POS_BITS)
        hv.block_align = hv.block_align |
                         (16'(b) << (8 * int'(hpos - wsp_pkg::POS_ALIGN)));
      else if (hpos >= wsp_pkg::POS_BITS)
        hv.bits = hv.bits | (16'(b) << (8 * int'(hpos - wsp_pkg::POS_BITS)));
      if (hpos == wsp_pkg::POS_HDR_LAST) begin
        ph     = wsp_pkg::PH_SEARCH;
        window = '0;
        hpos   = '0;
      end else begin
        hpos = hpos + 6'd1;
      end
    end
  endtask

  // one sample byte; a full frame gives one pwm level
  task automatic model_play_byte(input logic [7:0] b);
    logic        wide;
    logic        stereo;
    logic [1:0]  last;
    logic [15:0] smp;
    logic [16:0] mag;
    logic [7:0]  level;
    logic [8:0]  sum;
    wide   = (hv.bits == wsp_pkg::BITS_WIDE);
    stereo = (hv.channels == wsp_pkg::CHAN_STEREO);
    last   = wide ? (stereo ? 2'd3 : 2'd1) : (stereo ? 2'd1 : 2'd0);
    if (wide && !fpos[0]) begin
      low_byte = b;
      fpos     = fpos + 2'd1;
    end else begin
      if (wide) begin
        smp = {b, low_byte};
        // divide by 256 toward zero, then shift to the midpoint
        if (smp[15]) begin
          mag   = 17'h1_0000 - {1'b0, smp};
          level = wsp_pkg::PWM_MIDPOINT - mag[15:8];
        end else begin
          level = wsp_pkg::PWM_MIDPOINT + smp[15:8];
        end
      end else begin
        level = b;
      end
      if (fpos < last) begin
        first_level = level;
        fpos        = fpos + 2'd1;
      end else begin
        fpos = 2'd0;
        if (stereo) begin
          sum   = {1'b0, first_level} + {1'b0, level};
          level = sum[8:1];
        end
        note_result(wsp_pkg::KIND_SAMPLE, level);
      end
    end
  endtask

  // next state and expected result for one accepted word
  task automatic parse_wav_byte(input logic [1:0] f, input logic [7:0] b);
    case (f)
      wsp_pkg::FUNC_NEW: begin
        model_clear();
        ph = wsp_pkg::PH_HEADER;
        model_header_byte(b);
      end
      wsp_pkg::FUNC_END: begin
        if (ph == wsp_pkg::PH_HEADER || ph == wsp_pkg::PH_SEARCH ||
            ph == wsp_pkg::PH_SIZE) begin
          ph = wsp_pkg::PH_STOP;
          note_result(wsp_pkg::KIND_ERROR, 8'd0);
        end else if (ph == wsp_pkg::PH_PLAY) begin
          ph   = wsp_pkg::PH_STOP;
          fpos = 2'd0;
          note_result(wsp_pkg::KIND_END, wsp_pkg::PWM_MIDPOINT);
        end
      end
      wsp_pkg::FUNC_NEXT: begin
        case (ph)
          wsp_pkg::PH_HEADER: model_header_byte(b);
          wsp_pkg::PH_SEARCH: begin
            window = {window[23:0], b};
            if (window == wsp_pkg::TAG_DATA) begin
              ph           = wsp_pkg::PH_SIZE;
              hpos         = '0;
              hv.data_size = '0;
            end
          end
          wsp_pkg::PH_SIZE: begin
            hv.data_size = hv.data_size | (32'(b) << (8 * int'(hpos)));
            if (hpos == wsp_pkg::POS_SIZE_LAST) begin
              hpos = '0;
              ph   = wsp_pkg::PH_PLAY;
              fpos = 2'd0;
              note_result(wsp_pkg::KIND_FORMAT, 8'd0);
            end else begin
              hpos = hpos + 6'd1;
            end
          end
          wsp_pkg::PH_PLAY: model_play_byte(b);
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- driving

  task automatic send_word(input logic [1:0] f, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.file_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_wav_byte(f, b);
    if (f != FUNC_UNUSED) words_sent++;
  endtask

  // sender stops until every expected word is back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int take_pct);
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
  endtask

  // ---------------------------------------------------------------- file building

  task automatic add_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'(v >> (8 * i)));
  endtask

  task automatic add_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(8'(t >> (8 * i)));
  endtask

  task automatic build_header(input logic [15:0] chans, input logic [15:0] bits);
    file_bytes.delete();
    add_tag(wsp_pkg::TAG_RIFF);
    add_le($urandom, 4);
    add_tag(wsp_pkg::TAG_WAVE);
    add_tag(TAG_FMT);
    add_le(32'd16, 4);
    add_le(($urandom_range(3) == 0) ? 32'($urandom) : 32'(FMT_PCM), 2);
    add_le(32'(chans), 2);
    add_le($urandom, 4);
    add_le($urandom, 4);
    add_le($urandom, 2);
    add_le(32'(bits), 2);
  endtask

  // junk before the data tag, optionally with a near miss of the tag, then the tag and a data size
  task automatic add_data_chunk(input int junk, input bit near_miss);
    repeat (junk) file_bytes.push_back(8'($urandom));
    if (near_miss) begin
      file_bytes.push_back(wsp_pkg::TAG_DATA[31:24]);
      file_bytes.push_back(wsp_pkg::TAG_DATA[23:16]);
      file_bytes.push_back(wsp_pkg::TAG_DATA[15:8]);
    end
    add_tag(wsp_pkg::TAG_DATA);
    add_le($urandom, 4);
  endtask

  // first byte opens the file; stray unused words are mixed in now and then
  task automatic send_file_bytes(input int count);
    for (int i = 0; i < count && i < file_bytes.size(); i++) begin
      if (i > 0 && $urandom_range(99) < 3) send_word(FUNC_UNUSED, 8'($urandom));
      send_word((i == 0) ? wsp_pkg::FUNC_NEW : wsp_pkg::FUNC_NEXT, file_bytes[i]);
    end
  endtask

  task automatic send_random_file();
    logic [15:0] chans;
    logic [15:0] bits;
    int sel;
    int size_end;
    int idx;
    sel   = $urandom_range(99);
    chans = (sel < 45) ? CHAN_MONO : (sel < 90) ? wsp_pkg::CHAN_STEREO : 16'($urandom);
    sel   = $urandom_range(99);
    bits  = (sel < 45) ? wsp_pkg::BITS_WIDE : (sel < 85) ? BITS_NARROW : 16'($urandom);
    build_header(chans, bits);
    add_data_chunk($urandom_range(0, 6), $urandom_range(3) == 0);
    size_end = file_bytes.size();
    repeat ($urandom_range(0, 40)) file_bytes.push_back(8'($urandom));
    sel = $urandom_range(99);
    if (sel < 8) begin
      // broken tag, then a few bytes the block ignores
      idx = ($urandom_range(1) == 0) ? $urandom_range(0, 3) : $urandom_range(8, 11);
      file_bytes[idx] = file_bytes[idx] ^ (8'd1 << $urandom_range(7));
      send_file_bytes(idx + 1 + $urandom_range(0, 4));
      send_word(wsp_pkg::FUNC_END, 8'($urandom));
    end else if (sel < 16) begin
      // file ends before the data size is complete
      send_file_bytes($urandom_range(1, size_end - 1));
      send_word(wsp_pkg::FUNC_END, 8'($urandom));
    end else begin
      send_file_bytes(file_bytes.size());
      sel = $urandom_range(99);
      if (sel < 70) begin
        send_word(wsp_pkg::FUNC_END, 8'($urandom));
      end else if (sel >= 85) begin
        send_word(wsp_pkg::FUNC_END, 8'($urandom));
        repeat ($urandom_range(1, 3)) send_word(wsp_pkg::FUNC_NEXT, 8'($urandom));
        send_word(wsp_pkg::FUNC_END, 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // words with no open file
  task automatic test_ignored_words();
    send_word(wsp_pkg::FUNC_NEXT, 8'h00);
    send_word(wsp_pkg::FUNC_NEXT, 8'hFF);
    send_word(wsp_pkg::FUNC_END, 8'h00);
    send_word(FUNC_UNUSED, 8'hFF);
  endtask

  task automatic test_bad_tags();
    file_bytes.delete();
    add_tag(wsp_pkg::TAG_RIFF ^ 32'h0000_0001);
    send_file_bytes(4);
    // stopped: bytes and end of file are dropped
    send_word(wsp_pkg::FUNC_NEXT, 8'h52);
    send_word(wsp_pkg::FUNC_END, 8'h00);
    build_header(CHAN_MONO, BITS_NARROW);
    file_bytes[11] = file_bytes[11] ^ 8'h80;
    send_file_bytes(12);
  endtask

  task automatic test_early_end();
    // inside the fixed header, after a restart in mid header
    build_header(wsp_pkg::CHAN_STEREO, wsp_pkg::BITS_WIDE);
    send_file_bytes(10);
    send_file_bytes(21);
    send_word(wsp_pkg::FUNC_END, 8'hFF);
    // while searching for the data tag
    build_header(CHAN_MONO, wsp_pkg::BITS_WIDE);
    add_data_chunk(2, 1'b0);
    send_file_bytes(39);
    send_word(wsp_pkg::FUNC_END, 8'h00);
    // inside the data size
    build_header(CHAN_MONO, BITS_NARROW);
    add_data_chunk(0, 1'b0);
    send_file_bytes(42);
    send_word(wsp_pkg::FUNC_END, 8'hFF);
  endtask

  task automatic test_sample_extremes();
    // 16-bit mono around both rails and zero
    build_header(CHAN_MONO, wsp_pkg::BITS_WIDE);
    add_data_chunk(1, 1'b1);
    add_le(32'h8000, 2);
    add_le(32'h7FFF, 2);
    add_le(32'h0000, 2);
    add_le(32'hFFFF, 2);
    add_le(32'hFF00, 2);
    add_le(32'hFF01, 2);
    add_le(32'h00FF, 2);
    add_le(32'h0100, 2);
    send_file_bytes(file_bytes.size());
    send_word(wsp_pkg::FUNC_END, 8'hAA);
    // 16-bit stereo, partial frame dropped at the end
    build_header(wsp_pkg::CHAN_STEREO, wsp_pkg::BITS_WIDE);
    add_data_chunk(0, 1'b0);
    add_le(32'h8000_8000, 4);
    add_le(32'h7FFF_7FFF, 4);
    add_le(32'h7FFF_8000, 4);
    add_le(32'h0001_FFFF, 4);
    file_bytes.push_back(8'h55);
    send_file_bytes(file_bytes.size());
    send_word(wsp_pkg::FUNC_END, 8'h55);
    // 8-bit mono, cut off by a new file
    build_header(CHAN_MONO, BITS_NARROW);
    add_data_chunk(3, 1'b0);
    add_le(32'h7F80_FF00, 4);
    send_file_bytes(file_bytes.size());
    // 8-bit stereo
    build_header(wsp_pkg::CHAN_STEREO, BITS_NARROW);
    add_data_chunk(0, 1'b1);
    add_le(32'h0001_FEFF, 4);
    add_le(32'h0000_FFFF, 4);
    file_bytes.push_back(8'hFF);
    send_file_bytes(file_bytes.size());
    send_word(wsp_pkg::FUNC_END, 8'h00);
  endtask

  task automatic test_random_files(input int target);
    while (words_sent < target) send_random_file();
  endtask

  // receiver holds off while the sender keeps pushing a file
  task automatic test_long_stall();
    hold_cycles = HOLD_CYCLES;
    build_header(CHAN_MONO, BITS_NARROW);
    add_data_chunk(0, 1'b0);
    repeat (60) file_bytes.push_back(8'($urandom));
    send_file_bytes(file_bytes.size());
    send_word(wsp_pkg::FUNC_END, 8'h00);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_result();
    pwm_result_t r;
    if (awaited_results.size() == 0) begin
      $display("%0t: result word with nothing expected, expected none, actual kind %0d pwm %0h",
               $time, out_ch.kind, out_ch.pulse_width);
      errors++;
    end else begin
      r = awaited_results.pop_front();
      check_field("kind", 32'(r.kind), 32'(out_ch.kind));
      check_field("pulse_width", 32'(r.pwm), 32'(out_ch.pulse_width));
      check_field("format_code", 32'(r.hdr.format_code), 32'(out_ch.format_code));
      check_field("channel_count", 32'(r.hdr.channels), 32'(out_ch.channel_count));
      check_field("sample_bits", 32'(r.hdr.bits), 32'(out_ch.sample_bits));
      check_field("sample_rate", r.hdr.sample_rate, out_ch.sample_rate);
      check_field("byte_rate", r.hdr.byte_rate, out_ch.byte_rate);
      check_field("block_align", 32'(r.hdr.block_align), 32'(out_ch.block_align));
      check_field("data_size", r.hdr.data_size, out_ch.data_size);
    end
  endtask

  // result side: take words, stall at random or for a counted hold
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_result();
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= wsp_pkg::FUNC_NEXT;
    in_ch.file_byte <= 8'h00;
    model_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(25, 80);
    test_ignored_words();
    test_bad_tags();
    test_early_end();
    test_sample_extremes();
    wait_for_results();
    test_random_files(650);

    set_idling(80, 25);
    test_random_files(1050);

    set_idling(0, 0);
    test_long_stall();
    test_random_files(1450);

    wait_for_results();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
